// ----- rtl/core/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance package
// Widths, fixed-point constants and the CORDIC tables shared by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;

    // port widths
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 25;

    // Q30 fixed point for angles, sines, cosines and roots
    localparam int Q    = 30;
    localparam int UQ_W = Q + 1;
    localparam int CW   = Q + 4;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // angle reduction
    localparam int                LANES      = 4;
    localparam int                HALF_LANES = 2;
    localparam int                DIFF_W     = LON_W + 1;
    localparam int                MAG_W      = LON_W;
    localparam logic [63:0]       FULL_TURN_L = 64'd360 << ANGLE_FRAC_BITS;
    localparam logic [63:0]       HALF_TURN_L = FULL_TURN_L / 2;
    localparam int                FOLD_W     = $clog2(HALF_TURN_L + 1);
    localparam logic [MAG_W-1:0]  FULL_TURN  = MAG_W'(FULL_TURN_L);
    localparam logic [MAG_W-1:0]  HALF_TURN  = MAG_W'(HALF_TURN_L);

    // degrees to radians: multiply by round(pi/180 * 2^36), round-half-up shift
    localparam int          K_W        = 31;
    localparam logic [63:0] DEG_K_L    = ((PI_Q60 / 64'd180) + (64'd1 << 23)) >> 24;
    localparam logic [K_W-1:0] DEG_K   = K_W'(DEG_K_L);
    localparam int          PROD_W     = FOLD_W + K_W;
    localparam int          SH_FULL    = ANGLE_FRAC_BITS + 6;
    localparam int          SH_HALF    = ANGLE_FRAC_BITS + 7;
    localparam int          THETA_W    = Q + 2;

    localparam logic [63:0]        PI_Q30_L   = (PI_Q60 + (64'd1 << 29)) >> 30;
    localparam logic [THETA_W-1:0] PI_Q30     = THETA_W'(PI_Q30_L);
    localparam logic [THETA_W-1:0] THETA_FOLD = THETA_W'(PI_Q30_L / 2);
    localparam logic [63:0]        HALF_PI_L  = (PI_Q60 + (64'd1 << 30)) >> 31;

    localparam logic [UQ_W-1:0] ONE_Q30 = UQ_W'(64'd1 << Q);

    // square roots
    localparam int ROOT_W = UQ_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    // final scaling
    localparam int                SCALE_W    = 24;
    localparam logic [SCALE_W-1:0] DIST_SCALE = SCALE_W'(2 * 6371 * 1000);
    localparam logic [DIST_W-1:0] MAX_METRES = DIST_W'(20015087);

    // shift-subtract division for elaboration-time constants
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctangent of 2^-i in Q30 from its alternating series
    function automatic longint atan_q30(input int i);
        longint sum;
        longint term;
        int     e;
        if (i == 0) begin
            return longint'((PI_Q60 + (64'd1 << 31)) >> 32);
        end
        sum = 0;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > 60) begin
                break;
            end
            term = longint'(udiv(64'd1 << (60 - e), 64'(2 * k + 1)));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return (sum + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // inverse CORDIC gain, measured by vectoring the unit vector
    function automatic longint inv_gain_q30();
        longint x;
        longint y;
        longint nx;
        longint ny;
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
            end
            x = nx;
            y = ny;
        end
        if (x <= 0) begin
            x = 1;
        end
        return longint'(udiv((64'd1 << 60) + (64'(x) >> 1), 64'(x)));
    endfunction

    localparam logic signed [CW-1:0] INV_GAIN = CW'(inv_gain_q30());

endpackage

`default_nettype wire

// ----- rtl/core/gcd_prep.sv -----
// ----------------------------------------------------------------------------
// Angle preparation
// Forms the four angles (half latitude and longitude differences, both
// latitudes), folds them to [0, 180] degrees and converts to Q30 radians
// in the first quadrant with a flag for the second quadrant. Seven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_prep (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [gcd_pkg::LAT_W-1:0]  lat1,
    input  logic signed [gcd_pkg::LON_W-1:0]  lon1,
    input  logic signed [gcd_pkg::LAT_W-1:0]  lat2,
    input  logic signed [gcd_pkg::LON_W-1:0]  lon2,
    output logic                              out_valid,
    output logic signed [gcd_pkg::CW-1:0]     out_z [gcd_pkg::LANES],
    output logic                              out_neg [gcd_pkg::LANES]
);
    import gcd_pkg::*;

    localparam int DEPTH = 7;

    logic [DEPTH-1:0] valid_reg;

    logic signed [DIFF_W-1:0]  diff_next  [LANES];
    logic signed [DIFF_W-1:0]  diff_reg   [LANES];
    logic [MAG_W-1:0]          mag_reg    [LANES];
    logic [MAG_W-1:0]          red_reg    [LANES];
    logic [FOLD_W-1:0]         fold_reg   [LANES];
    logic [PROD_W-1:0]         prod_reg   [LANES];
    logic [THETA_W-1:0]        theta_next [LANES];
    logic [THETA_W-1:0]        theta_reg  [LANES];
    logic signed [CW-1:0]      z_reg      [LANES];
    logic                      neg_reg    [LANES];

    always_comb begin
        diff_next[0] = DIFF_W'(lat2) - DIFF_W'(lat1);
        diff_next[1] = DIFF_W'(lon2) - DIFF_W'(lon1);
        diff_next[2] = DIFF_W'(lat1);
        diff_next[3] = DIFF_W'(lat2);
    end

    // differences take half the angle: one more bit of shift
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (l < HALF_LANES) begin
                theta_next[l] = THETA_W'(({1'b0, prod_reg[l]}
                                + ((PROD_W + 1)'(1) << (SH_HALF - 1))) >> SH_HALF);
            end else begin
                theta_next[l] = THETA_W'(({1'b0, prod_reg[l]}
                                + ((PROD_W + 1)'(1) << (SH_FULL - 1))) >> SH_FULL);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                diff_reg[l] <= diff_next[l];
                mag_reg[l]  <= diff_reg[l][DIFF_W-1] ? MAG_W'(-diff_reg[l])
                                                     : MAG_W'(diff_reg[l]);
                red_reg[l]  <= (mag_reg[l] >= FULL_TURN) ? mag_reg[l] - FULL_TURN
                                                         : mag_reg[l];
                fold_reg[l] <= (red_reg[l] > HALF_TURN) ? FOLD_W'(FULL_TURN - red_reg[l])
                                                        : FOLD_W'(red_reg[l]);
                prod_reg[l] <= PROD_W'(fold_reg[l]) * PROD_W'(DEG_K);
                theta_reg[l] <= theta_next[l];
                // mirror the second quadrant onto the first
                if (theta_reg[l] > THETA_FOLD) begin
                    z_reg[l]   <= CW'(PI_Q30 - theta_reg[l]);
                    neg_reg[l] <= 1'b1;
                end else begin
                    z_reg[l]   <= CW'(theta_reg[l]);
                    neg_reg[l] <= 1'b0;
                end
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_z     = z_reg;
    assign out_neg   = neg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gcd_rot_cordic.sv -----
// ----------------------------------------------------------------------------
// Rotation CORDIC
// One stage per iteration; starts from the inverse gain on the x axis and
// returns cosine in x and sine in y. A tag bit rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_rot_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [gcd_pkg::CW-1:0] in_z,
    input  logic                          in_tag,
    output logic                          out_valid,
    output logic signed [gcd_pkg::CW-1:0] out_x,
    output logic signed [gcd_pkg::CW-1:0] out_y,
    output logic                          out_tag
);
    import gcd_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES];
    logic                 tag_reg [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] valid_reg;

    genvar i;
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
        logic signed [CW-1:0] x_prev;
        logic signed [CW-1:0] y_prev;
        logic signed [CW-1:0] z_prev;
        logic                 tag_prev;
        logic                 valid_prev;

        if (i == 0) begin : g_first
            assign x_prev     = INV_GAIN;
            assign y_prev     = '0;
            assign z_prev     = in_z;
            assign tag_prev   = in_tag;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign x_prev     = x_reg[i-1];
            assign y_prev     = y_reg[i-1];
            assign z_prev     = z_reg[i-1];
            assign tag_prev   = tag_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[i] <= tag_prev;
                if (z_prev >= 0) begin
                    x_reg[i] <= x_prev - (y_prev >>> i);
                    y_reg[i] <= y_prev + (x_prev >>> i);
                    z_reg[i] <= z_prev - ATAN;
                end else begin
                    x_reg[i] <= x_prev + (y_prev >>> i);
                    y_reg[i] <= y_prev - (x_prev >>> i);
                    z_reg[i] <= z_prev + ATAN;
                end
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign out_x     = x_reg[CORDIC_STAGES-1];
    assign out_y     = y_reg[CORDIC_STAGES-1];
    assign out_tag   = tag_reg[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/gcd_haversine.sv -----
// ----------------------------------------------------------------------------
// Haversine term
// a = sin^2(dlat/2) + sin^2(dlon/2) * cos(lat1) * cos(lat2), held to [0, 1],
// then the two radicands a and 1 - a in Q60. Eight stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_haversine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [gcd_pkg::CW-1:0]    sin_dlat,
    input  logic signed [gcd_pkg::CW-1:0]    sin_dlon,
    input  logic signed [gcd_pkg::CW-1:0]    cos_lat1,
    input  logic                             neg_lat1,
    input  logic signed [gcd_pkg::CW-1:0]    cos_lat2,
    input  logic                             neg_lat2,
    output logic                             out_valid,
    output logic [gcd_pkg::RAD_W-1:0]        rad_y,
    output logic [gcd_pkg::RAD_W-1:0]        rad_x
);
    import gcd_pkg::*;

    localparam int DEPTH = 8;
    localparam int P_W   = 2 * UQ_W;
    localparam int A_W   = UQ_W + 2;
    localparam logic [P_W:0] RND = (P_W + 1)'(1) << (Q - 1);

    logic [DEPTH-1:0] valid_reg;

    logic [UQ_W-1:0] s1_reg, s2_reg, c1_reg, c2_reg;
    logic            n1_reg, n2_reg;
    logic [P_W-1:0]  p1_reg, p2_reg, p3_reg;
    logic            opp2_reg, opp3_reg, opp4_reg, opp5_reg;
    logic [UQ_W-1:0] s1sq_reg, s2sq_reg, cc_reg;
    logic [UQ_W-1:0] s1sq4_reg, s1sq5_reg;
    logic [P_W-1:0]  pt_reg;
    logic [UQ_W-1:0] term_reg;
    logic signed [A_W-1:0] a_reg;
    logic [UQ_W-1:0] ac_reg;
    logic [RAD_W-1:0] rad_y_reg, rad_x_reg;

    function automatic logic [UQ_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > CW'(ONE_Q30)) begin
            return ONE_Q30;
        end
        return UQ_W'(v);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg <= clamp_unit(sin_dlat);
            s2_reg <= clamp_unit(sin_dlon);
            c1_reg <= clamp_unit(cos_lat1);
            c2_reg <= clamp_unit(cos_lat2);
            n1_reg <= neg_lat1;
            n2_reg <= neg_lat2;

            // a cosine clamped to zero carries no sign
            p1_reg   <= P_W'(s1_reg) * P_W'(s1_reg);
            p2_reg   <= P_W'(s2_reg) * P_W'(s2_reg);
            p3_reg   <= P_W'(c1_reg) * P_W'(c2_reg);
            opp2_reg <= (n1_reg && c1_reg != '0) != (n2_reg && c2_reg != '0);

            s1sq_reg <= UQ_W'(({1'b0, p1_reg} + RND) >> Q);
            s2sq_reg <= UQ_W'(({1'b0, p2_reg} + RND) >> Q);
            cc_reg   <= UQ_W'(({1'b0, p3_reg} + RND) >> Q);
            opp3_reg <= opp2_reg;

            pt_reg    <= P_W'(s2sq_reg) * P_W'(cc_reg);
            s1sq4_reg <= s1sq_reg;
            opp4_reg  <= opp3_reg;

            term_reg  <= UQ_W'(({1'b0, pt_reg} + RND) >> Q);
            s1sq5_reg <= s1sq4_reg;
            opp5_reg  <= opp4_reg;

            a_reg <= opp5_reg ? A_W'(s1sq5_reg) - A_W'(term_reg)
                              : A_W'(s1sq5_reg) + A_W'(term_reg);

            if (a_reg < 0) begin
                ac_reg <= '0;
            end else if (a_reg > A_W'(ONE_Q30)) begin
                ac_reg <= ONE_Q30;
            end else begin
                ac_reg <= UQ_W'(a_reg);
            end

            rad_y_reg <= RAD_W'(ac_reg) << Q;
            rad_x_reg <= RAD_W'(ONE_Q30 - ac_reg) << Q;
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign rad_y     = rad_y_reg;
    assign rad_x     = rad_x_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gcd_isqrt.sv -----
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [gcd_pkg::RAD_W-1:0]     in_rad,
    output logic                          out_valid,
    output logic [gcd_pkg::ROOT_W-1:0]    out_root
);
    import gcd_pkg::*;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [ROOT_W-1:0] valid_reg;

    genvar j;
    for (j = 0; j < ROOT_W; j++) begin : g_digit
        localparam int PAIR_LO = 2 * (ROOT_W - 1 - j);
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic              valid_prev;
        logic [REM_W+1:0]  rem_shift;
        logic [REM_W+1:0]  trial;

        if (j == 0) begin : g_first
            assign rem_prev   = '0;
            assign root_prev  = '0;
            assign rad_prev   = in_rad;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign rem_prev   = rem_reg[j-1];
            assign root_prev  = root_reg[j-1];
            assign rad_prev   = rad_reg[j-1];
            assign valid_prev = valid_reg[j-1];
        end

        // bring down the next bit pair, try 4*root + 1
        assign rem_shift = {rem_prev, rad_prev[PAIR_LO+1:PAIR_LO]};
        assign trial     = (REM_W + 2)'({root_prev, 2'b01});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[j] <= rad_prev;
                if (rem_shift >= trial) begin
                    rem_reg[j]  <= REM_W'(rem_shift - trial);
                    root_reg[j] <= {root_prev[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[j]  <= REM_W'(rem_shift);
                    root_reg[j] <= {root_prev[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/gcd_vec_cordic.sv -----
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// One stage per iteration; drives y to zero and accumulates the angle
// atan2(y, x) in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_vec_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [gcd_pkg::ROOT_W-1:0]    in_x,
    input  logic [gcd_pkg::ROOT_W-1:0]    in_y,
    output logic                          out_valid,
    output logic signed [gcd_pkg::CW-1:0] out_z
);
    import gcd_pkg::*;

    logic signed [CW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES];
    logic signed [CW-1:0] z_reg [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] valid_reg;

    genvar i;
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
        logic signed [CW-1:0] x_prev;
        logic signed [CW-1:0] y_prev;
        logic signed [CW-1:0] z_prev;
        logic                 valid_prev;

        if (i == 0) begin : g_first
            assign x_prev     = CW'(in_x);
            assign y_prev     = CW'(in_y);
            assign z_prev     = '0;
            assign valid_prev = in_valid;
        end else begin : g_next
            assign x_prev     = x_reg[i-1];
            assign y_prev     = y_reg[i-1];
            assign z_prev     = z_reg[i-1];
            assign valid_prev = valid_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (y_prev >= 0) begin
                    x_reg[i] <= x_prev + (y_prev >>> i);
                    y_reg[i] <= y_prev - (x_prev >>> i);
                    z_reg[i] <= z_prev + ATAN;
                end else begin
                    x_reg[i] <= x_prev - (y_prev >>> i);
                    y_reg[i] <= y_prev + (x_prev >>> i);
                    z_reg[i] <= z_prev - ATAN;
                end
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STAGES-1];
    assign out_z     = z_reg[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/core/great_circle_distance_unit.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance unit
// Haversine distance between two points on a 6371 km sphere, in metres.
// ----------------------------------------------------------------------------
// Takes one point pair per cycle while s_ready is high and returns one
// rounded distance per pair, in order, through angle preparation, 24
// rotation CORDIC stages, 8 haversine stages, 31 square root stages, 24
// vectoring CORDIC stages, 3 scaling stages and the output register. The
// whole pipeline advances together; when the output register and the
// one-entry skid register behind it are both full, s_ready drops until the
// consumer takes a result. Latitudes and longitudes are signed fixed point
// in 2^-16 degree; out-of-range angles wrap modulo 360 degrees.
`default_nettype none

module great_circle_distance_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [gcd_pkg::LAT_W-1:0]   s_first_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]   s_first_longitude,
    input  logic signed [gcd_pkg::LAT_W-1:0]   s_second_latitude,
    input  logic signed [gcd_pkg::LON_W-1:0]   s_second_longitude,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gcd_pkg::DIST_W-1:0]         m_distance_metres
);
    import gcd_pkg::*;

    localparam int ZC_W   = UQ_W;
    localparam int DP_W   = ZC_W + SCALE_W;
    localparam int DR_W   = DP_W + 1 - Q;
    localparam logic [CW-1:0] HALF_PI = CW'(HALF_PI_L);

    logic en;

    logic                 prep_valid;
    logic signed [CW-1:0] prep_z   [LANES];
    logic                 prep_neg [LANES];

    logic [LANES-1:0]     rot_valid;
    logic signed [CW-1:0] rot_x   [LANES];
    logic signed [CW-1:0] rot_y   [LANES];
    logic                 rot_tag [LANES];

    logic              hav_valid;
    logic [RAD_W-1:0]  rad_y;
    logic [RAD_W-1:0]  rad_x;

    logic [1:0]        sqrt_valid;
    logic [ROOT_W-1:0] root_y;
    logic [ROOT_W-1:0] root_x;

    logic                 vec_valid;
    logic signed [CW-1:0] vec_z;

    logic [2:0]        scale_valid_reg;
    logic [ZC_W-1:0]   zc_reg;
    logic [DP_W-1:0]   dprod_reg;
    logic [DR_W-1:0]   dround_reg;
    logic [DIST_W-1:0] dist_clamped;

    logic              m_valid_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic              skid_valid_reg;
    logic [DIST_W-1:0] skid_dist_reg;

    // the pipeline runs while the skid register is free
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    gcd_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .lat1      (s_first_latitude),
        .lon1      (s_first_longitude),
        .lat2      (s_second_latitude),
        .lon2      (s_second_longitude),
        .out_valid (prep_valid),
        .out_z     (prep_z),
        .out_neg   (prep_neg)
    );

    genvar l;
    for (l = 0; l < LANES; l++) begin : g_lane
        gcd_rot_cordic u_rot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (prep_valid),
            .in_z      (prep_z[l]),
            .in_tag    (prep_neg[l]),
            .out_valid (rot_valid[l]),
            .out_x     (rot_x[l]),
            .out_y     (rot_y[l]),
            .out_tag   (rot_tag[l])
        );
    end

    gcd_haversine u_hav (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (&rot_valid),
        .sin_dlat  (rot_y[0]),
        .sin_dlon  (rot_y[1]),
        .cos_lat1  (rot_x[2]),
        .neg_lat1  (rot_tag[2]),
        .cos_lat2  (rot_x[3]),
        .neg_lat2  (rot_tag[3]),
        .out_valid (hav_valid),
        .rad_y     (rad_y),
        .rad_x     (rad_x)
    );

    gcd_isqrt u_sqrt_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (hav_valid),
        .in_rad    (rad_y),
        .out_valid (sqrt_valid[0]),
        .out_root  (root_y)
    );

    gcd_isqrt u_sqrt_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (hav_valid),
        .in_rad    (rad_x),
        .out_valid (sqrt_valid[1]),
        .out_root  (root_x)
    );

    gcd_vec_cordic u_vec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (&sqrt_valid),
        .in_x      (root_x),
        .in_y      (root_y),
        .out_valid (vec_valid),
        .out_z     (vec_z)
    );

    // scale half the central angle by the diameter in metres
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_valid_reg <= '0;
        end else if (en) begin
            scale_valid_reg <= {scale_valid_reg[1:0], vec_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (vec_z < 0) begin
                zc_reg <= '0;
            end else if (vec_z > signed'(HALF_PI)) begin
                zc_reg <= ZC_W'(HALF_PI);
            end else begin
                zc_reg <= ZC_W'(vec_z);
            end
            dprod_reg  <= DP_W'(zc_reg) * DP_W'(DIST_SCALE);
            dround_reg <= DR_W'(({1'b0, dprod_reg} + ((DP_W + 1)'(1) << (Q - 1))) >> Q);
        end
    end

    assign dist_clamped = (dround_reg > DR_W'(MAX_METRES)) ? MAX_METRES
                                                           : DIST_W'(dround_reg);

    // output register with one skid entry behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                m_dist_reg     <= skid_dist_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (scale_valid_reg[2]) begin
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= 1'b1;
                m_dist_reg  <= dist_clamped;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_dist_reg  <= dist_clamped;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_distance_metres = m_dist_reg;

`ifndef SYNTHESIS
    a_skid_behind_output : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held without a result at the output");

    a_no_request_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !s_ready)
        else $error("request taken while skid entry is full");

    a_skid_fill_on_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid entry filled while the output was free");

    a_distance_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_dist_reg <= MAX_METRES)
        else $error("distance beyond half circumference");
`endif

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Great-circle distance unit testbench
// Drives random and corner point pairs, predicts each haversine distance in
// fixed point and checks the results in order, with random stalls on both
// sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class distance_scoreboard;
    logic [24:0] pending_q[$];
    int          errors;
    longint      atan_tab[24];
    longint      inv_gain;

    function new();
        longint x;
        longint y;
        longint nx;
        longint ny;
        longint s;
        longint t;
        int     e;
        errors = 0;
        atan_tab[0] = longint'((64'h3243F6A8885A308D + (64'd1 << 31)) >> 32);
        for (int i = 1; i < 24; i++) begin
            s = 0;
            for (int k = 0; k < 64; k++) begin
                e = i * (2 * k + 1);
                if (e > 60) break;
                t = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
                s = (k % 2 == 1) ? s - t : s + t;
            end
            atan_tab[i] = (s + (64'sd1 <<< 29)) >>> 30;
        end
        x = 64'sd1 <<< 30;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i);
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i);
            end
            x = nx; y = ny;
        end
        if (x <= 0) x = 1;
        inv_gain = longint'(((64'd1 << 60) + 64'(x) / 2) / 64'(x));
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // magnitude of an angle reduced to [0, 180] degrees
    function longint fold(longint d);
        longint full;
        longint r;
        full = longint'(360) << 16;
        r = d % full;
        if (r < 0) r += full;
        if (r > full / 2) r = full - r;
        return r;
    endfunction

    function longint to_rad(longint r, int extra);
        logic [63:0] k;
        int          sh;
        k  = ((64'h3243F6A8885A308D / 64'd180) + (64'd1 << 23)) >> 24;
        sh = 22 + extra;
        return longint'((64'(r) * k + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function void rotate(longint theta, output longint sn, output longint cs);
        longint pi30;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        bit     neg;
        pi30 = longint'((64'h3243F6A8885A308D + (64'd1 << 29)) >> 30);
        x = inv_gain; y = 0; z = theta; neg = 0;
        if (theta > pi30 / 2) begin
            z = pi30 - theta; neg = 1;
        end
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
            end
            x = nx; y = ny;
        end
        sn = clamp(y, 0, 64'sd1 <<< 30);
        x  = clamp(x, 0, 64'sd1 <<< 30);
        cs = neg ? -x : x;
    endfunction

    function longint root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function longint mulq(longint a, longint b);
        return longint'((64'(a) * 64'(b) + (64'd1 << 29)) >> 30);
    endfunction

    function logic [24:0] distance(longint lat1, longint lon1, longint lat2, longint lon2);
        longint s1, c1, s2, c2, sa, ca, sb, cb, a, x, y, z, nx, ny, term, d, hp;
        rotate(to_rad(fold(lat2 - lat1), 1), s1, c1);
        rotate(to_rad(fold(lon2 - lon1), 1), s2, c2);
        rotate(to_rad(fold(lat1), 0), sa, ca);
        rotate(to_rad(fold(lat2), 0), sb, cb);
        term = mulq(mulq(s2, s2), mulq(ca < 0 ? -ca : ca, cb < 0 ? -cb : cb));
        a = ((ca < 0) != (cb < 0)) ? mulq(s1, s1) - term : mulq(s1, s1) + term;
        a = clamp(a, 0, 64'sd1 <<< 30);
        y = root(64'(a) << 30);
        x = root(64'((64'sd1 <<< 30) - a) << 30);
        z = 0;
        for (int i = 0; i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
            end
            x = nx; y = ny;
        end
        hp = longint'((64'h3243F6A8885A308D + (64'd1 << 30)) >> 31);
        z = clamp(z, 0, hp);
        d = longint'((64'(z) * 64'd12742000 + (64'd1 << 29)) >> 30);
        if (d > 20015087) d = 20015087;
        return d[24:0];
    endfunction

    function void note_request(logic signed [23:0] la1, logic signed [24:0] lo1,
                               logic signed [23:0] la2, logic signed [24:0] lo2);
        pending_q.insert(pending_q.size(), distance(la1, lo1, la2, lo2));
    endfunction

    function void check_result(logic [24:0] got);
        logic [24:0] want;
        if (pending_q.size() == 0) begin
            $error("distance_metres: none expected, actual %0d", got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        if (got !== want) begin
            $error("distance_metres: expected %0d, actual %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb;
    import gcd_pkg::*;

    localparam longint LAT_MAX = 5898240;
    localparam longint LON_MAX = 11796480;

    logic                     aclk = 0;
    logic                     aresetn = 0;
    logic                     s_valid = 0;
    logic                     s_ready;
    logic signed [LAT_W-1:0]  s_first_latitude = '0;
    logic signed [LON_W-1:0]  s_first_longitude = '0;
    logic signed [LAT_W-1:0]  s_second_latitude = '0;
    logic signed [LON_W-1:0]  s_second_longitude = '0;
    logic                     m_valid;
    logic                     m_ready = 0;
    logic [DIST_W-1:0]        m_distance_metres;

    distance_scoreboard board = new();
    bit                 calm_phase = 0;
    bit                 hold_output = 0;

    great_circle_distance_unit u_top (.*);

    always #4 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // random stalls on the result side, plus the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_output && (calm_phase || $urandom_range(99) >= 19);
        if (aresetn && m_valid && m_ready) board.check_result(m_distance_metres);
    end

    task automatic send_pair(longint la1, longint lo1, longint la2, longint lo2);
        while (!calm_phase && $urandom_range(99) < 19) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid            <= 1;
        s_first_latitude   <= LAT_W'(la1);
        s_first_longitude  <= LON_W'(lo1);
        s_second_latitude  <= LAT_W'(la2);
        s_second_longitude <= LON_W'(lo2);
        do @(posedge aclk); while (!s_ready);
        board.note_request(s_first_latitude, s_first_longitude,
                           s_second_latitude, s_second_longitude);
    endtask

    function automatic longint any_lat();
        case ($urandom_range(9))
            0: return $signed(24'($urandom));
            1: return ($urandom_range(1) ? LAT_MAX : -LAT_MAX);
            default: return longint'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
        endcase
    endfunction

    function automatic longint any_lon();
        case ($urandom_range(9))
            0: return $signed(25'($urandom));
            1: return ($urandom_range(1) ? LON_MAX : -LON_MAX);
            default: return longint'($urandom_range(2 * LON_MAX)) - LON_MAX;
        endcase
    endfunction

    task automatic send_random(int count);
        longint la, lo;
        for (int n = 0; n < count; n++) begin
            la = any_lat(); lo = any_lon();
            case ($urandom_range(4))
                // near points and antipodes stress the ends of the arcsine
                0: send_pair(la, lo, la + $signed($urandom_range(64)) - 32,
                             lo + $signed($urandom_range(64)) - 32);
                1: send_pair(la, lo, -la, lo + (LON_MAX ^ 0) - (lo > 0 ? 2 * LON_MAX : 0));
                default: send_pair(la, lo, any_lat(), any_lon());
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // corners: same point, poles, antipodes, field extremes, wrapping
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 1, 0);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(24'sh7FFFFF, 25'sh0FFFFFF, -24'sh800000, -25'sh1000000);
        send_pair(-24'sh800000, -25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
        send_pair(-1, -1, -1, -1);
        send_pair(LAT_MAX + 65536, 0, 0, 0);
        send_pair(2621440, 655360, -2621440, 655360 + LON_MAX);
        send_pair(3276800, 1310720, 3276801, 1310720);
        send_pair(0, 0, 0, LON_MAX - 1);
        send_random(400);
        // fill the pipeline against a stopped consumer
        hold_output <= 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_output <= 0;
            end
            send_random(150);
        join
        // drain pause
        s_valid <= 0;
        while (board.pending_q.size() != 0) @(posedge aclk);
        calm_phase <= 1;
        send_random(400);
        calm_phase <= 0;
        send_random(1050);
        s_valid <= 0;
        while (board.pending_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (board.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/gcd_pkg.sv
rtl/core/gcd_prep.sv
rtl/core/gcd_rot_cordic.sv
rtl/core/gcd_haversine.sv
rtl/core/gcd_isqrt.sv
rtl/core/gcd_vec_cordic.sv
rtl/core/great_circle_distance_unit.sv
test/tb.sv
